>>> design/pcorr_pkg.sv
// ----------------------------------------------------------------------------
// pcorr_pkg
// Shared widths, word types, codes and control structs of the Pearson
// correlation engine.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  // Sizing
  localparam int MAX_SAMPLES  = 4096;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);              // holds MAX_SAMPLES + 1
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_SAMPLES) + 1;
  localparam int SQ_W   = 2 * SAMPLE_WIDTH + $clog2(MAX_SAMPLES);
  localparam int XP_W   = SQ_W + 1;
  localparam int WIDE_W = 64;    // variance / covariance terms
  localparam int PROD_W = 128;   // vx * vy
  localparam int CMP_W  = 160;   // trial product and cov^2 * 2^32
  localparam int Q_W    = 16;
  localparam int BIT_W  = $clog2(Q_W);
  localparam int CORR_W = 16;

  // Words
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ref_sample;
    logic signed [SAMPLE_WIDTH-1:0] gene_sample;
    logic                           last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [1:0]               status;
  } out_word_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Multiplier operations
  typedef enum logic [3:0] {
    OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NSXY, OP_SXSY,
    OP_CSQ, OP_PROD, OP_TRIAL
  } op_e;

  typedef enum logic [2:0] {
    S_ACC, S_CHECK, S_START, S_WAIT, S_VAR, S_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic             acc_en;
    logic             mul_start;
    logic             store;
    op_e              op;
    logic [BIT_W-1:0] trial_bit;
    logic             emit;
    status_e          emit_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_over;
    logic var_zero;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/pcorr_ctrl.sv
// ----------------------------------------------------------------------------
// pcorr_ctrl
// Sequencer: accumulates, walks the multiply steps and the 16-step root
// search, then emits one result word; overflow and zero variance skip ahead.
// ----------------------------------------------------------------------------
module pcorr_ctrl
  import pcorr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  status_e          est_q, est_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      op_q    <= OP_NSXX;
      bit_q   <= '0;
      est_q   <= ST_VALID;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      bit_q   <= bit_d;
      est_q   <= est_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    bit_d   = bit_q;
    est_d   = est_q;
    in_stall_o        = 1'b1;
    cmd_o.acc_en      = 1'b0;
    cmd_o.mul_start   = 1'b0;
    cmd_o.store       = 1'b0;
    cmd_o.op          = op_q;
    cmd_o.trial_bit   = bit_q;
    cmd_o.emit        = 1'b0;
    cmd_o.emit_status = est_q;
    unique case (state_q)
      S_ACC: begin
        in_stall_o   = 1'b0;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.cnt_over) begin
          est_d   = ST_OVERFLOW;
          state_d = S_EMIT;
        end else begin
          op_d    = OP_NSXX;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.store = 1'b1;
          state_d = S_START;
          unique case (op_q)
            OP_NSXX: op_d = OP_SXSX;
            OP_SXSX: op_d = OP_NSYY;
            OP_NSYY: op_d = OP_SYSY;
            OP_SYSY: op_d = OP_NSXY;
            OP_NSXY: op_d = OP_SXSY;
            OP_SXSY: state_d = S_VAR;
            OP_CSQ:  op_d = OP_PROD;
            OP_PROD: begin
              op_d  = OP_TRIAL;
              bit_d = BIT_W'(Q_W - 1);
            end
            OP_TRIAL: begin
              if (bit_q == '0) begin
                est_d   = ST_VALID;
                state_d = S_EMIT;
              end else begin
                bit_d = bit_q - 1'b1;
              end
            end
            default: state_d = S_ACC;
          endcase
        end
      end
      S_VAR: begin
        if (sts_i.var_zero) begin
          est_d   = ST_ZERO_VAR;
          state_d = S_EMIT;
        end else begin
          op_d    = OP_CSQ;
          state_d = S_START;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

endmodule

>>> design/pcorr_datapath.sv
// ----------------------------------------------------------------------------
// pcorr_datapath
// Accumulators, shift-add multiplier, variance/covariance registers,
// root search register and the output word register.
// ----------------------------------------------------------------------------
module pcorr_datapath
  import pcorr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Accumulators
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic [SQ_W-1:0]         sxx_q, syy_q;
  logic signed [XP_W-1:0]  sxy_q;

  logic signed [2*SAMPLE_WIDTH-1:0] xx, yy, xy;
  assign xx = in_word_i.ref_sample * in_word_i.ref_sample;
  assign yy = in_word_i.gene_sample * in_word_i.gene_sample;
  assign xy = in_word_i.ref_sample * in_word_i.gene_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0;
      sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
    end else if (cmd_i.emit) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0;
      sxx_q <= '0; syy_q <= '0; sxy_q <= '0;
    end else if (cmd_i.acc_en && cnt_q <= CNT_W'(MAX_SAMPLES)) begin
      cnt_q <= cnt_q + 1'b1;
      // one pair past the limit bumps only the count; later ones are ignored
      if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
        sx_q  <= sx_q + SUM_W'(in_word_i.ref_sample);
        sy_q  <= sy_q + SUM_W'(in_word_i.gene_sample);
        sxx_q <= sxx_q + SQ_W'($unsigned(xx));
        syy_q <= syy_q + SQ_W'($unsigned(yy));
        sxy_q <= sxy_q + XP_W'(xy);
      end
    end
  end

  // Magnitudes
  logic [SUM_W-1:0]  sx_abs, sy_abs;
  logic [XP_W-1:0]   sxy_abs;
  logic [WIDE_W-1:0] cw_abs;
  logic signed [WIDE_W-1:0] t_q, vx_q, vy_q, cw_q;
  logic [PROD_W-1:0] p_q;
  logic [CMP_W-1:0]  c_q;
  logic [Q_W-1:0]    q_q;

  assign sx_abs  = sx_q[SUM_W-1]  ? SUM_W'(-sx_q)  : SUM_W'(sx_q);
  assign sy_abs  = sy_q[SUM_W-1]  ? SUM_W'(-sy_q)  : SUM_W'(sy_q);
  assign sxy_abs = sxy_q[XP_W-1]  ? XP_W'(-sxy_q)  : XP_W'(sxy_q);
  assign cw_abs  = cw_q[WIDE_W-1] ? WIDE_W'(-cw_q) : WIDE_W'(cw_q);

  // Trial candidate and (2c-1)^2
  logic [Q_W-1:0]     cand;
  logic [Q_W:0]       dval;
  logic [2*Q_W+1:0]   dsq;
  assign cand = q_q | (Q_W'(1) << cmd_i.trial_bit);
  assign dval = {cand, 1'b0} - (Q_W+1)'(1);
  assign dsq  = dval * dval;

  // Operand select
  logic [PROD_W-1:0] opa;
  logic [WIDE_W-1:0] opb;
  logic              opneg;
  always_comb begin
    opa = '0; opb = '0; opneg = 1'b0;
    case (cmd_i.op)
      OP_NSXX: begin opa = PROD_W'(cnt_q); opb = WIDE_W'(sxx_q); end
      OP_SXSX: begin opa = PROD_W'(sx_abs); opb = WIDE_W'(sx_abs); end
      OP_NSYY: begin opa = PROD_W'(cnt_q); opb = WIDE_W'(syy_q); end
      OP_SYSY: begin opa = PROD_W'(sy_abs); opb = WIDE_W'(sy_abs); end
      OP_NSXY: begin
        opa = PROD_W'(cnt_q); opb = WIDE_W'(sxy_abs); opneg = sxy_q[XP_W-1];
      end
      OP_SXSY: begin
        opa = PROD_W'(sx_abs); opb = WIDE_W'(sy_abs);
        opneg = sx_q[SUM_W-1] ^ sy_q[SUM_W-1];
      end
      OP_CSQ:   begin opa = PROD_W'(cw_abs); opb = cw_abs; end
      OP_PROD:  begin opa = PROD_W'($unsigned(vx_q)); opb = WIDE_W'($unsigned(vy_q)); end
      OP_TRIAL: begin opa = p_q; opb = WIDE_W'(dsq); end
      default:  opneg = 1'b0;
    endcase
  end

  // Shift-add multiplier, one multiplier bit per cycle
  logic [CMP_W-1:0]  ma_q, macc_q;
  logic [WIDE_W-1:0] mb_q;
  logic              mneg_q, mbusy_q, mul_done;
  assign mul_done = mbusy_q && (mb_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mbusy_q <= 1'b1;
    end else if (mul_done) begin
      mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      ma_q   <= CMP_W'(opa);
      mb_q   <= opb;
      macc_q <= '0;
      mneg_q <= opneg;
    end else if (mbusy_q && !mul_done) begin
      if (mb_q[0]) macc_q <= macc_q + ma_q;
      ma_q <= {ma_q[CMP_W-2:0], 1'b0};
      mb_q <= {1'b0, mb_q[WIDE_W-1:1]};
    end
  end

  logic signed [WIDE_W-1:0] prod64;
  assign prod64 = mneg_q ? -$signed(macc_q[WIDE_W-1:0]) : $signed(macc_q[WIDE_W-1:0]);

  // Result registers of each step
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      case (cmd_i.op)
        OP_NSXX, OP_NSYY, OP_NSXY: t_q <= prod64;
        OP_SXSX: vx_q <= t_q - prod64;
        OP_SYSY: vy_q <= t_q - prod64;
        OP_SXSY: cw_q <= t_q - prod64;
        OP_CSQ:  c_q  <= {macc_q[CMP_W-33:0], 32'd0};
        OP_PROD: p_q  <= macc_q[PROD_W-1:0];
        default: t_q  <= t_q;
      endcase
    end
  end

  // Root search: keep the largest q with (2q-1)^2 * vx * vy <= cov^2 * 2^32
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (cmd_i.emit) begin
      q_q <= '0;
    end else if (cmd_i.store && cmd_i.op == OP_TRIAL && macc_q <= c_q) begin
      q_q <= cand;
    end
  end

  // Final sign and saturation
  logic signed [CORR_W-1:0] corr;
  always_comb begin
    corr = '0;
    if (cmd_i.emit_status == ST_VALID) begin
      if (cw_q[WIDE_W-1]) begin
        corr = (q_q > Q_W'(32768)) ? CORR_W'(-32768) : CORR_W'(-$signed({1'b0, q_q}));
      end else begin
        corr = (q_q > Q_W'(32767)) ? CORR_W'(32767) : CORR_W'(q_q);
      end
    end
  end

  // Output word register
  logic      out_valid_q;
  out_word_t out_word_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q.correlation <= corr;
      out_word_q.status      <= cmd_i.emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign sts_o.cnt_over = cnt_q > CNT_W'(MAX_SAMPLES);
  assign sts_o.var_zero = (vx_q == '0) || (vy_q == '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

>>> design/pearson_correlation_engine_core.sv
// ----------------------------------------------------------------------------
// pearson_correlation_engine_core
// Streams sample pairs, accumulates sums and emits the Pearson coefficient
// of each gene row in Q1.15 with a status code.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+------------------------------------
//   in      | in  | in_valid_i/in_stall_o  | ref_sample, gene_sample, last_sample
//   out     | out | out_valid_o/out_stall_i| correlation, status
//
// One pair is taken per cycle while accumulating. After the last pair the
// shared shift-add multiplier runs 8 products plus 16 root-search trial
// products; each runs for as long as its second operand has significant
// bits left, so a row with full-scale sums takes longest and one with small
// sums far less. Zero-variance and over-limit rows finish early.
// The input stalls from the last pair until the result word is issued.
// A pending output word does not block accumulation of the next row.
// Reset is asynchronous, active low, and clears all sums.
// ----------------------------------------------------------------------------
module pearson_correlation_engine_core
  import pcorr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  pcorr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_sample),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcorr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free) else $error("result emitted over a pending word");

  a_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.mul_done) else $error("multiplier active while accumulating");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_VALID |-> out_word_o.correlation == '0)
    else $error("error status with nonzero correlation");

endmodule

>>> tb/sv/tb_pearson_correlation_engine_core.sv
// ----------------------------------------------------------------------------
// tb_pearson_correlation_engine_core
// Self-checking bench for the Pearson correlation engine. Rows of sample
// pairs are driven in bursts with random gaps. A predictor accumulates the
// same sums and works out each row's coefficient with an exact integer
// root search. Output words are compared in order with the predicted ones.
// ----------------------------------------------------------------------------
module tb_pearson_correlation_engine_core;
  import pcorr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  pearson_correlation_engine_core dut (.*);

  // Clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  in_word_t  pair_q[$];
  out_word_t coeff_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        stim_done = 1'b0;

  // Predictor state
  int unsigned     pair_count;
  longint          sum_x, sum_y, sum_xx, sum_yy, sum_xy;

  function automatic void clear_sums();
    pair_count = 0;
    sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
  endfunction

  // Accumulate one pair; on the row's last pair push the expected word
  function automatic void predict_pair(in_word_t w);
    longint    x, y;
    logic [63:0] vx, vy, cw, cabs, n, d;
    logic [255:0] prod, rhs, lhs;
    bit        neg;
    int        q, c;
    out_word_t r;
    x = longint'(w.ref_sample);
    y = longint'(w.gene_sample);
    if (pair_count <= MAX_SAMPLES) begin
      pair_count++;
      if (pair_count <= MAX_SAMPLES) begin
        sum_x += x; sum_y += y;
        sum_xx += x * x; sum_yy += y * y; sum_xy += x * y;
      end
    end
    if (!w.last_sample) return;
    r.correlation = '0;
    if (pair_count > MAX_SAMPLES) begin
      r.status = ST_OVERFLOW;
    end else begin
      n  = 64'(pair_count);
      vx = n * 64'(sum_xx) - 64'(sum_x) * 64'(sum_x);
      vy = n * 64'(sum_yy) - 64'(sum_y) * 64'(sum_y);
      cw = n * 64'(sum_xy) - 64'(sum_x) * 64'(sum_y);
      neg = cw[63];
      cabs = neg ? (~cw + 64'd1) : cw;
      if (vx == 0 || vy == 0) begin
        r.status = ST_ZERO_VAR;
      end else begin
        prod = 256'(vx) * 256'(vy);
        rhs = (256'(cabs) * 256'(cabs)) << 32;
        q = 0;
        // Largest q with (2q-1)^2 * vx * vy <= cov^2 * 2^32
        for (int b = 15; b >= 0; b--) begin
          c = q | (1 << b);
          d = 64'(2 * c - 1);
          lhs = prod * 256'(d * d);
          if (lhs <= rhs) q = c;
        end
        if (neg) q = -q;
        else if (q > 32767) q = 32767;
        r.correlation = 16'(q);
        r.status = ST_VALID;
      end
    end
    coeff_q.push_back(r);
    clear_sums();
  endfunction

  // Driver: bursts of valid with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) predict_pair(in_word_i);
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pair_q.size() > 0) begin
        in_word_i  <= pair_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: runs of free and stalled cycles
  int stall_run = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= $urandom_range(0, 30);
    end
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (coeff_q.size() == 0) begin
          $error("unexpected word: correlation %0d status %0d",
                 out_word_o.correlation, out_word_o.status);
          mismatches++;
        end else begin
          e = coeff_q.pop_front();
          if (out_word_o.correlation !== e.correlation) begin
            $error("correlation: expected %0d, actual %0d", e.correlation,
                   out_word_o.correlation);
            mismatches++;
          end
          if (out_word_o.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_word_o.status);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic in_word_t make_pair(int x, int y, bit last);
    in_word_t w;
    w.ref_sample = 16'(x);
    w.gene_sample = 16'(y);
    w.last_sample = last;
    return w;
  endfunction

  // Push one row; mode picks the shape of the data
  task automatic push_row(int len, int mode);
    int x, y, k;
    k = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(0, 65535) - 32768;
      case (mode)
        0: y = $urandom_range(0, 65535) - 32768;
        1: y = (k > 0) ? x : ~x;
        2: y = x / 2 + int'($urandom_range(0, 200)) - 100;
        default: y = 1234;
      endcase
      pair_q.push_back(make_pair(x, y, i == len - 1));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    clear_sums();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows
    pair_q.push_back(make_pair(100, 200, 1));             // single pair, zero variance
    pair_q.push_back(make_pair(-32768, 32767, 0));        // extremes, perfect negative
    pair_q.push_back(make_pair(32767, -32768, 1));
    pair_q.push_back(make_pair(-32768, -32768, 0));       // perfect positive, saturates
    pair_q.push_back(make_pair(32767, 32767, 1));
    pair_q.push_back(make_pair(5, 1, 0));                 // constant gene row
    pair_q.push_back(make_pair(-5, 1, 0));
    pair_q.push_back(make_pair(0, 1, 1));
    pair_q.push_back(make_pair(1, 3, 0));
    pair_q.push_back(make_pair(2, -7, 0));
    pair_q.push_back(make_pair(3, 4, 1));
    push_row(6, 2);

    // Random rows, mostly short
    for (int r = 0; r < 70; r++)
      push_row($urandom_range(1, 12), $urandom_range(0, 3));
    // Trailing noise pairs fold into one final row
    push_row($urandom_range(1, 5), 0);

    wait (pair_q.size() == 0 && !in_valid_i);
    wait (coeff_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
